// ===== sv/cmls_pkg.sv =====
// Shared types, codes and constants of the cycler mode and limit supervisor.
package cmls_pkg;

  localparam int unsigned TICKS_PER_MS  = 10;
  localparam int unsigned POWER_DIVISOR = 100000;

  // Mode codes; six and seven are unknown modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_WAIT  = 3'd1;
  localparam logic [2:0] MODE_CV    = 3'd2;
  localparam logic [2:0] MODE_CC    = 3'd3;
  localparam logic [2:0] MODE_CP    = 3'd4;
  localparam logic [2:0] MODE_ERROR = 3'd5;

  // Limit kinds
  localparam logic [1:0] LIM_TIME = 2'd0;
  localparam logic [1:0] LIM_VOLT = 2'd1;
  localparam logic [1:0] LIM_CURR = 2'd2;
  localparam logic [1:0] LIM_PWR  = 2'd3;

  // Limit states
  localparam logic [1:0] ST_REACHED     = 2'd0;
  localparam logic [1:0] ST_NOT_REACHED = 2'd1;
  localparam logic [1:0] ST_ALREADY     = 2'd2;
  localparam logic [1:0] ST_ERROR       = 2'd3;

  // Directions
  localparam logic [1:0] DIR_CHARGE    = 2'd0;
  localparam logic [1:0] DIR_DISCHARGE = 2'd1;
  localparam logic [1:0] DIR_WAIT      = 2'd2;

  // Drive commands
  localparam logic [1:0] DRV_NONE    = 2'd0;
  localparam logic [1:0] DRV_DISABLE = 2'd1;
  localparam logic [1:0] DRV_APPLY   = 2'd2;
  localparam logic [1:0] DRV_ENABLE  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_REQ_MODE       = 3'd0;
  localparam logic [2:0] CFG_REQ_LIMIT_TYPE = 3'd1;
  localparam logic [2:0] CFG_REQ_MODE_REF   = 3'd2;
  localparam logic [2:0] CFG_REQ_LIMIT_REF  = 3'd3;
  localparam logic [2:0] CFG_REQ_OUT_EN     = 3'd4;
  localparam logic [2:0] CFG_SETTLE_TIME    = 3'd5;

  typedef struct packed {
    logic [2:0]  req_mode;
    logic [1:0]  req_limit_type;
    logic [15:0] req_mode_ref;
    logic [15:0] req_limit_ref;
    logic        req_output_enable;
    logic [15:0] settle_time_ms;
  } cfg_t;

  // Request after the power pipeline
  typedef struct packed {
    logic        command;
    logic [15:0] ls_volt;
    logic [15:0] ls_curr;
    logic [15:0] power;
  } item_t;

  typedef struct packed {
    logic        step_status;
    logic [1:0]  drive_command;
    logic [1:0]  regulation_mode;
    logic [15:0] regulation_ref;
    logic [2:0]  current_mode;
    logic [1:0]  limit_status;
    logic [1:0]  direction;
    logic [31:0] elapsed_ms;
    logic        output_on;
  } result_t;

endpackage

// ===== sv/cmls_power.sv =====
// Two-stage power pipeline: current times voltage, then divide by a constant.
module cmls_power import cmls_pkg::*; #(
  parameter int unsigned PowerDivisor = POWER_DIVISOR
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic        command_i,
  input  logic [15:0] ls_volt_i,
  input  logic [15:0] ls_curr_i,
  output logic        valid_o,
  output item_t       item_o
);

  // Exact quotient by reciprocal for a 31-bit magnitude
  localparam int unsigned DivLog   = $clog2(PowerDivisor);
  localparam int unsigned Shift    = 31 + DivLog;
  localparam logic [63:0] RecipFull =
    ((64'd1 << Shift) + 64'(PowerDivisor) - 64'd1) / 64'(PowerDivisor);
  localparam logic [31:0] Recip    = RecipFull[31:0];

  logic signed [31:0] prod;
  logic [30:0]        mag;

  logic        s1_valid_q;
  logic        s1_cmd_q;
  logic [15:0] s1_volt_q;
  logic [15:0] s1_curr_q;
  logic [30:0] s1_mag_q;
  logic        s1_neg_q;

  logic [62:0] qfull;
  logic [62:0] quo;
  logic [15:0] pwr_d;

  logic  s2_valid_q;
  item_t s2_item_q;

  // Voltage is taken as a signed 16-bit value here
  assign prod = $signed(ls_curr_i) * $signed(ls_volt_i);
  assign mag  = prod[31] ? 31'(-prod) : prod[30:0];

  assign qfull = 63'(s1_mag_q) * 63'(Recip);
  assign quo   = qfull >> Shift;
  assign pwr_d = s1_neg_q ? 16'(-quo[15:0]) : quo[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_cmd_q          <= command_i;
      s1_volt_q         <= ls_volt_i;
      s1_curr_q         <= ls_curr_i;
      s1_mag_q          <= mag;
      s1_neg_q          <= prod[31];
      s2_item_q.command <= s1_cmd_q;
      s2_item_q.ls_volt <= s1_volt_q;
      s2_item_q.ls_curr <= s1_curr_q;
      s2_item_q.power   <= pwr_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign item_o  = s2_item_q;

endmodule

// ===== sv/cmls_supervisor.sv =====
// Mode state, millisecond timer and limit checks for one request per cycle while fire_i is high.
module cmls_supervisor import cmls_pkg::*; #(
  parameter int unsigned TicksPerMs = TICKS_PER_MS
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [2:0]  mode_q, mode_d;
  logic [1:0]  lt_q, lt_d;
  logic [15:0] mref_q, mref_d;
  logic [15:0] lref_q, lref_d;
  logic        out_on_q, out_on_d;
  logic [1:0]  lstate_q, lstate_d;
  logic [1:0]  action_q, action_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [3:0]  presc_q, presc_d;

  logic [3:0]         presc_inc;
  logic [31:0]        el_tick;
  logic               settled;
  logic               chg;
  logic signed [16:0] lu_s;
  logic signed [16:0] curr_s;
  logic signed [16:0] pwr_s;
  logic               time_hit;
  logic               volt_hit;
  logic [1:0]         chk;
  logic               is_reg;
  logic [1:0]         dir_apply;

  assign presc_inc = presc_q + 4'd1;
  assign el_tick   = (presc_inc >= 4'(TicksPerMs) && elapsed_q != '1) ?
                     elapsed_q + 32'd1 : elapsed_q;
  assign settled   = el_tick >= {16'd0, cfg_i.settle_time_ms};
  assign chg       = action_q == DIR_CHARGE;
  assign lu_s      = $signed({1'b0, lref_q});
  assign curr_s    = $signed({item_i.ls_curr[15], item_i.ls_curr});
  assign pwr_s     = $signed({item_i.power[15], item_i.power});
  assign time_hit  = el_tick >= {{16{lref_q[15]}}, lref_q};
  assign volt_hit  = chg ? (item_i.ls_volt >= lref_q) : (item_i.ls_volt <= lref_q);

  // Limit check of a tick, in the order of the mode then the limit kind
  always_comb begin
    chk = ST_NOT_REACHED;
    case (mode_q)
      MODE_CV: begin
        if (lt_q == LIM_CURR && (chg ? curr_s <= lu_s : curr_s >= lu_s) && settled) begin
          chk = ST_REACHED;
        end else if (lt_q == LIM_PWR && settled) begin
          if (chg ? pwr_s <= lu_s : pwr_s >= lu_s) begin
            chk = ST_REACHED;
          end
        end
      end
      MODE_CC: begin
        if (lt_q == LIM_VOLT && volt_hit) begin
          chk = ST_REACHED;
        end else if (lt_q == LIM_PWR && settled && pwr_s >= lu_s) begin
          chk = ST_REACHED;
        end
      end
      MODE_CP: begin
        if (lt_q == LIM_VOLT && volt_hit) begin
          chk = ST_REACHED;
        end else if (lt_q == LIM_CURR && curr_s <= lu_s && settled) begin
          chk = ST_REACHED;
        end
      end
      default: begin
        chk = (action_q == DIR_WAIT) ? ST_NOT_REACHED : ST_ERROR;
      end
    endcase
  end

  assign is_reg = cfg_i.req_mode inside {MODE_CV, MODE_CC, MODE_CP};

  always_comb begin
    case (cfg_i.req_mode)
      MODE_CV: begin
        dir_apply = ($signed({cfg_i.req_mode_ref[15], cfg_i.req_mode_ref}) >=
                     $signed({1'b0, item_i.ls_volt})) ? DIR_CHARGE : DIR_DISCHARGE;
      end
      MODE_CC, MODE_CP: begin
        dir_apply = cfg_i.req_mode_ref[15] ? DIR_DISCHARGE : DIR_CHARGE;
      end
      default: begin
        dir_apply = DIR_WAIT;
      end
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    lt_d      = lt_q;
    mref_d    = mref_q;
    lref_d    = lref_q;
    out_on_d  = out_on_q;
    lstate_d  = lstate_q;
    action_d  = action_q;
    elapsed_d = elapsed_q;
    presc_d   = presc_q;
    res_o.step_status     = 1'b0;
    res_o.drive_command   = DRV_NONE;
    res_o.regulation_mode = 2'd0;
    res_o.regulation_ref  = 16'd0;
    if (fire_i) begin
      if (item_i.command) begin
        // Apply: load the requested mode; prescaler holds its count
        mode_d    = cfg_i.req_mode;
        lt_d      = cfg_i.req_limit_type;
        mref_d    = cfg_i.req_mode_ref;
        lref_d    = cfg_i.req_limit_ref;
        action_d  = dir_apply;
        elapsed_d = 32'd0;
        lstate_d  = (cfg_i.req_mode == MODE_ERROR || cfg_i.req_mode == MODE_IDLE) ?
                    ST_ALREADY : ST_NOT_REACHED;
        out_on_d  = is_reg && cfg_i.req_output_enable;
        if (!cfg_i.req_output_enable) begin
          res_o.drive_command = DRV_DISABLE;
        end else if (is_reg) begin
          res_o.drive_command = DRV_ENABLE;
        end else begin
          res_o.step_status = 1'b1;
        end
      end else begin
        presc_d   = (presc_inc >= 4'(TicksPerMs)) ? 4'd0 : presc_inc;
        elapsed_d = el_tick;
        if (lt_q == LIM_TIME) begin
          lstate_d = time_hit ? ST_REACHED : lstate_q;
        end else begin
          lstate_d = chk;
        end
        case (lstate_d)
          ST_NOT_REACHED: begin
            case (mode_q)
              MODE_IDLE: begin
              end
              MODE_WAIT: begin
                res_o.drive_command = DRV_DISABLE;
                out_on_d            = 1'b0;
              end
              MODE_CV, MODE_CC, MODE_CP: begin
                res_o.drive_command   = DRV_APPLY;
                res_o.regulation_mode = 2'(mode_q - MODE_CV);
                res_o.regulation_ref  = mref_q;
              end
              default: begin
                res_o.drive_command = DRV_DISABLE;
                out_on_d            = 1'b0;
                res_o.step_status   = 1'b1;
              end
            endcase
          end
          ST_REACHED: begin
            // Fall back to idle with the output off
            mode_d              = MODE_IDLE;
            lt_d                = LIM_TIME;
            mref_d              = 16'd0;
            lref_d              = 16'd0;
            out_on_d            = 1'b0;
            action_d            = DIR_WAIT;
            elapsed_d           = 32'd0;
            lstate_d            = ST_ALREADY;
            res_o.drive_command = DRV_DISABLE;
          end
          ST_ERROR: begin
            res_o.step_status = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
    res_o.current_mode = mode_d;
    res_o.limit_status = lstate_d;
    res_o.direction    = action_d;
    res_o.elapsed_ms   = elapsed_d;
    res_o.output_on    = out_on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      lt_q      <= LIM_TIME;
      mref_q    <= 16'd0;
      lref_q    <= 16'd0;
      out_on_q  <= 1'b0;
      lstate_q  <= ST_ALREADY;
      action_q  <= DIR_WAIT;
      elapsed_q <= 32'd0;
      presc_q   <= 4'd0;
    end else begin
      mode_q    <= mode_d;
      lt_q      <= lt_d;
      mref_q    <= mref_d;
      lref_q    <= lref_d;
      out_on_q  <= out_on_d;
      lstate_q  <= lstate_d;
      action_q  <= action_d;
      elapsed_q <= elapsed_d;
      presc_q   <= presc_d;
    end
  end

endmodule

// ===== sv/cycler_mode_limit_supervisor_core.sv =====
// Top level of the cycler mode and limit supervisor.
//
// Requests enter on in_valid_i / in_stall_o with command_i (0 control tick,
// 1 apply requested mode), ls_volt_i and ls_curr_i. Each request yields
// exactly one result on out_valid_o / out_stall_i, in request order.
// The requested mode, limit and settle time are set beforehand on the
// configuration port (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i),
// which is always ready; writes with an unused index are dropped.
// An accepted request passes the power product register, then the register
// of its constant divide, and then the result register, which loads from
// one pass through the mode state, timer and limit checks.
// Throughput is one request per cycle unless a valid result is stalled;
// the mode state is the only loop and it closes within that single pass.
// Reset returns to idle mode, limit already reached, direction wait, elapsed
// time and prescaler zero, and clears all configuration registers.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall_o rises in the same cycle; nothing is dropped or repeated.
module cycler_mode_limit_supervisor_core import cmls_pkg::*; #(
  parameter int unsigned TicksPerMs   = TICKS_PER_MS,
  parameter int unsigned PowerDivisor = POWER_DIVISOR
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [15:0] ls_volt_i,
  input  logic [15:0] ls_curr_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        step_status_o,
  output logic [1:0]  drive_command_o,
  output logic [1:0]  regulation_mode_o,
  output logic [15:0] regulation_ref_o,
  output logic [2:0]  current_mode_o,
  output logic [1:0]  limit_status_o,
  output logic [1:0]  direction_o,
  output logic [31:0] elapsed_ms_o,
  output logic        output_on_o
);

  cfg_t    cfg_q;
  logic    advance;
  logic    s2_valid;
  item_t   s2_item;
  logic    fire;
  result_t res;
  logic    out_valid_q;
  result_t out_q;

  // Advance the pipeline whenever the result register is free or being taken
  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !advance;
  assign fire        = advance && s2_valid;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_REQ_MODE:       cfg_q.req_mode          <= cfg_data_i[2:0];
        CFG_REQ_LIMIT_TYPE: cfg_q.req_limit_type    <= cfg_data_i[1:0];
        CFG_REQ_MODE_REF:   cfg_q.req_mode_ref      <= cfg_data_i;
        CFG_REQ_LIMIT_REF:  cfg_q.req_limit_ref     <= cfg_data_i;
        CFG_REQ_OUT_EN:     cfg_q.req_output_enable <= cfg_data_i[0];
        CFG_SETTLE_TIME:    cfg_q.settle_time_ms    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cmls_power #(
    .PowerDivisor(PowerDivisor)
  ) u_power (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .valid_i  (in_valid_i),
    .command_i(command_i),
    .ls_volt_i(ls_volt_i),
    .ls_curr_i(ls_curr_i),
    .valid_o  (s2_valid),
    .item_o   (s2_item)
  );

  cmls_supervisor #(
    .TicksPerMs(TicksPerMs)
  ) u_supervisor (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(s2_item),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  // Result register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign step_status_o     = out_q.step_status;
  assign drive_command_o   = out_q.drive_command;
  assign regulation_mode_o = out_q.regulation_mode;
  assign regulation_ref_o  = out_q.regulation_ref;
  assign current_mode_o    = out_q.current_mode;
  assign limit_status_o    = out_q.limit_status;
  assign direction_o       = out_q.direction;
  assign elapsed_ms_o      = out_q.elapsed_ms;
  assign output_on_o       = out_q.output_on;

endmodule
